FILE: sv/chunk_stream_cap_scanner_core_defines.svh
// assertion macros for the chunk stream cap scanner checker
// no dependencies; included by the checker file
`ifndef CHUNK_STREAM_CAP_SCANNER_CORE_DEFINES_SVH
`define CHUNK_STREAM_CAP_SCANNER_CORE_DEFINES_SVH

// clocked assertion, disabled while reset is asserted
`define CSC_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define CSC_ASSERT_ALWAYS(lbl, ck, prop, msg) \
    lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

FILE: sv/csc_pkg.sv
// shared types and constants for the chunk stream cap scanner
// no dependencies
package csc_pkg;

    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned LIMIT_W     = 28;

    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_TAG      = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FILE_SIZE_LIMIT = 1'b1;

    localparam logic [31:0]        TARGET_TAG_RESET = 32'd1313296460;
    localparam logic [LIMIT_W-1:0] FILE_LIMIT_RESET = 28'd67108864;

    localparam logic [7:0]  NEUTRAL_CODE = 8'd104;
    localparam logic [7:0]  CAP_SATURATE = 8'd255;
    localparam logic [31:0] SMALL_LEN    = 32'd4;
    localparam logic [31:0] TABLE_LEN    = 32'd256;

    localparam logic [1:0] STATUS_NONE    = 2'd0;
    localparam logic [1:0] STATUS_DECIDED = 2'd1;
    localparam logic [1:0] STATUS_OVER    = 2'd2;

    typedef struct packed {
        logic [7:0] cap_value;
        logic [1:0] scan_status;
    } csc_result_t;

endpackage

FILE: sv/csc_stream_if.sv
// valid/ready channel interfaces for input bytes and scan results
// no dependencies
interface csc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface csc_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] cap_value;
    logic [1:0] scan_status;

    modport source (output valid, output cap_value, output scan_status, input ready);
    modport sink   (input valid, input cap_value, input scan_status, output ready);
endinterface

FILE: sv/chunk_stream_cap_scanner_core.sv
// top level: config registers, input word register, parser, result register
// depends on csc_pkg, csc_stream_if.sv, csc_parser
//
//  channel     dir   payload                      handshake
//  byte_in     in    data_byte[7:0], is_last      valid/ready
//  result_out  out   cap_value[7:0], scan_status  valid/ready
//  cfg         in    cfg_index, cfg_data[31:0]    cfg_we, no wait
//
// one word accepted per cycle unless the input word register is stalled
// each taken word is parsed from the input word register
// the result register decouples the sides; only a last word waits on it
// rst_n clears control state and loads the register defaults
module chunk_stream_cap_scanner_core (
    input  logic                              clk,
    input  logic                              rst_n,
    csc_byte_if.sink                          byte_in,
    csc_result_if.source                      result_out,
    input  logic                              cfg_we,
    input  logic [csc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [csc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import csc_pkg::*;

    logic [31:0]        target_tag_reg;
    logic [LIMIT_W-1:0] limit_reg;

    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic        out_vld_reg;
    csc_result_t out_res_reg;

    csc_result_t parse_res;
    logic        advance;

    assign advance       = in_vld_reg && (!in_last_reg || !out_vld_reg || result_out.ready);
    assign byte_in.ready = !in_vld_reg || advance;

    assign result_out.valid       = out_vld_reg;
    assign result_out.cap_value   = out_res_reg.cap_value;
    assign result_out.scan_status = out_res_reg.scan_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_tag_reg <= TARGET_TAG_RESET;
            limit_reg      <= FILE_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TARGET_TAG:      target_tag_reg <= cfg_data;
                REG_FILE_SIZE_LIMIT: limit_reg      <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            in_byte_reg <= 8'd0;
            in_last_reg <= 1'b0;
        end
        else if (byte_in.ready)
        begin
            in_vld_reg  <= byte_in.valid;
            in_byte_reg <= byte_in.data_byte;
            in_last_reg <= byte_in.is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            out_res_reg <= '0;
        end
        else if (advance && in_last_reg)
        begin
            out_vld_reg <= 1'b1;
            out_res_reg <= parse_res;
        end
        else if (result_out.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    csc_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (advance),
        .data_byte       (in_byte_reg),
        .is_last         (in_last_reg),
        .target_tag      (target_tag_reg),
        .file_size_limit (limit_reg),
        .result          (parse_res)
    );

endmodule

FILE: sv/csc_parser.sv
// chunk header walker, body skip, value and maximum collection, size limit
// depends on csc_pkg
module csc_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic [7:0]                   data_byte,
    input  logic                         is_last,
    input  logic [31:0]                  target_tag,
    input  logic [csc_pkg::LIMIT_W-1:0]  file_size_limit,
    output csc_pkg::csc_result_t         result
);
    import csc_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_VALUE4,
        PH_MAX256,
        PH_DONE,
        PH_OVER
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [2:0]         hdr_cnt_reg, hdr_cnt_next;
    logic [31:0]        tag_reg, tag_next;
    logic [23:0]        len_reg, len_next;
    logic [31:0]        body_reg, body_next;
    logic [23:0]        acc_reg, acc_next;
    logic [7:0]         decided_reg, decided_next;
    logic [LIMIT_W-1:0] seen_reg, seen_next;

    logic [31:0] len_full;
    logic [31:0] value_full;
    logic [7:0]  byte_code;
    logic [7:0]  max_val;

    assign len_full   = {data_byte, len_reg};
    assign value_full = {data_byte, acc_reg};
    assign byte_code  = (data_byte == 8'd0) ? NEUTRAL_CODE : data_byte;
    assign max_val    = (byte_code > acc_reg[7:0]) ? byte_code : acc_reg[7:0];

    always_comb
    begin
        phase_next   = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        tag_next     = tag_reg;
        len_next     = len_reg;
        body_next    = body_reg;
        acc_next     = acc_reg;
        decided_next = decided_reg;
        seen_next    = seen_reg;
        result.cap_value   = 8'd0;
        result.scan_status = STATUS_NONE;

        if (en)
        begin
            if (phase_reg != PH_OVER)
            begin
                if (seen_reg >= file_size_limit)
                begin
                    phase_next = PH_OVER;
                end
                else
                begin
                    seen_next = seen_reg + 1'b1;
                    case (phase_reg)
                        PH_HEADER:
                        begin
                            case (hdr_cnt_reg)
                                3'd0: tag_next[7:0]   = data_byte;
                                3'd1: tag_next[15:8]  = data_byte;
                                3'd2: tag_next[23:16] = data_byte;
                                3'd3: tag_next[31:24] = data_byte;
                                3'd4: len_next[7:0]   = data_byte;
                                3'd5: len_next[15:8]  = data_byte;
                                3'd6: len_next[23:16] = data_byte;
                                default: ;
                            endcase
                            if (hdr_cnt_reg == 3'd7)
                            begin
                                hdr_cnt_next = 3'd0;
                                acc_next     = 24'd0;
                                if (tag_reg == target_tag && len_full == SMALL_LEN)
                                begin
                                    body_next  = SMALL_LEN;
                                    phase_next = PH_VALUE4;
                                end
                                else if (tag_reg == target_tag && len_full == TABLE_LEN)
                                begin
                                    body_next  = TABLE_LEN;
                                    acc_next   = {16'd0, NEUTRAL_CODE};
                                    phase_next = PH_MAX256;
                                end
                                else
                                begin
                                    body_next  = len_full;
                                    phase_next = (len_full == 32'd0) ? PH_HEADER : PH_SKIP;
                                end
                                tag_next = 32'd0;
                                len_next = 24'd0;
                            end
                            else
                            begin
                                hdr_cnt_next = hdr_cnt_reg + 3'd1;
                            end
                        end
                        PH_SKIP:
                        begin
                            body_next = body_reg - 32'd1;
                            if (body_reg == 32'd1)
                                phase_next = PH_HEADER;
                        end
                        PH_VALUE4:
                        begin
                            body_next = body_reg - 32'd1;
                            case (body_reg[2:0])
                                3'd4: acc_next[7:0]   = data_byte;
                                3'd3: acc_next[15:8]  = data_byte;
                                3'd2: acc_next[23:16] = data_byte;
                                default: ;
                            endcase
                            if (body_reg == 32'd1)
                            begin
                                phase_next = PH_DONE;
                                if (value_full == 32'd0 || value_full == {24'd0, NEUTRAL_CODE})
                                    decided_next = 8'd0;
                                else if (value_full[31:8] != 24'd0)
                                    decided_next = CAP_SATURATE;
                                else
                                    decided_next = value_full[7:0];
                            end
                        end
                        PH_MAX256:
                        begin
                            body_next = body_reg - 32'd1;
                            acc_next  = {16'd0, max_val};
                            if (body_reg == 32'd1)
                            begin
                                phase_next   = PH_DONE;
                                decided_next = (max_val == NEUTRAL_CODE) ? 8'd0 : max_val;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            if (is_last)
            begin
                if (phase_next == PH_OVER)
                begin
                    result.scan_status = STATUS_OVER;
                end
                else if (phase_next == PH_DONE)
                begin
                    result.cap_value   = decided_next;
                    result.scan_status = STATUS_DECIDED;
                end
                phase_next   = PH_HEADER;
                hdr_cnt_next = 3'd0;
                tag_next     = 32'd0;
                len_next     = 24'd0;
                body_next    = 32'd0;
                acc_next     = 24'd0;
                decided_next = 8'd0;
                seen_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            hdr_cnt_reg <= 3'd0;
            tag_reg     <= 32'd0;
            len_reg     <= 24'd0;
            body_reg    <= 32'd0;
            acc_reg     <= 24'd0;
            decided_reg <= 8'd0;
            seen_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;
            tag_reg     <= tag_next;
            len_reg     <= len_next;
            body_reg    <= body_next;
            acc_reg     <= acc_next;
            decided_reg <= decided_next;
            seen_reg    <= seen_next;
        end
    end

endmodule

FILE: sv/csc_checker.sv
// port-level checks for chunk_stream_cap_scanner_core, attached by bind
// depends on csc_pkg and chunk_stream_cap_scanner_core_defines.svh
`include "chunk_stream_cap_scanner_core_defines.svh"

module csc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_is_last,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_cap_value,
    input logic [1:0] out_scan_status
);
    import csc_pkg::*;

    // stalled result holds
    `CSC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_cap_value) && $stable(out_scan_status), "result changed while stalled")

    // only defined status codes
    `CSC_ASSERT(a_status_code, clk, rst_n, out_valid |-> (out_scan_status == STATUS_NONE || out_scan_status == STATUS_DECIDED || out_scan_status == STATUS_OVER), "bad scan status")

    // no cap unless decided
    `CSC_ASSERT(a_cap_zero, clk, rst_n, out_valid && out_scan_status != STATUS_DECIDED |-> out_cap_value == 8'd0, "cap without decision")

    // a fresh result follows an accepted last word
    `CSC_ASSERT(a_result_cause, clk, rst_n, $rose(out_valid) |-> $past(in_valid && in_ready && in_is_last, 2), "result without last word")

endmodule

bind chunk_stream_cap_scanner_core csc_checker u_csc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (byte_in.valid),
    .in_ready        (byte_in.ready),
    .in_is_last      (byte_in.is_last),
    .out_valid       (result_out.valid),
    .out_ready       (result_out.ready),
    .out_cap_value   (result_out.cap_value),
    .out_scan_status (result_out.scan_status)
);

FILE: test/chunk_stream_cap_scanner_core_tb.sv
// testbench for chunk_stream_cap_scanner_core: streams chunked files a word at a time
// and checks every cap result against a predictor of the chunk walk
// depends on csc_pkg, csc_stream_if.sv and chunk_stream_cap_scanner_core
`timescale 1ns / 1ps

module chunk_stream_cap_scanner_core_tb;
    import csc_pkg::*;

    typedef enum logic [2:0] {
        SCAN_HEADER,
        SCAN_SKIP,
        SCAN_VALUE4,
        SCAN_MAX256,
        SCAN_DONE,
        SCAN_OVER
    } scan_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } byte_word_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    csc_byte_if   byte_ch ();
    csc_result_if res_ch ();

    chunk_stream_cap_scanner_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_ch),
        .result_out (res_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    byte_word_t  pending_words[$];
    csc_result_t cap_expected[$];
    logic [7:0]  file_buf[$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int files_sent;
    int words_sent;
    int results_checked;
    int status_seen[3];

    // register mirror
    logic [31:0]        cfg_tag;
    logic [LIMIT_W-1:0] cfg_limit;

    // predictor state
    scan_phase_t scan_phase;
    logic [2:0]  hdr_count;
    logic [31:0] tag_acc;
    logic [31:0] len_acc;
    logic [31:0] body_left;
    logic [31:0] value_acc;
    logic [7:0]  decided_cap;
    logic [31:0] seen_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("chunk_stream_cap_scanner_core_tb failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic append_file_byte(input logic [7:0] b);
        file_buf = {file_buf, b};
    endtask

    task automatic queue_word(input byte_word_t w);
        pending_words = {pending_words, w};
    endtask

    task automatic queue_expected(input csc_result_t r);
        cap_expected = {cap_expected, r};
    endtask

    task automatic clear_scan();
        scan_phase  = SCAN_HEADER;
        hdr_count   = 3'd0;
        tag_acc     = 32'd0;
        len_acc     = 32'd0;
        body_left   = 32'd0;
        value_acc   = 32'd0;
        decided_cap = 8'd0;
        seen_count  = 32'd0;
    endtask

    task automatic settle_cap(input logic [31:0] v);
        if (v == 32'd0 || v == 32'(NEUTRAL_CODE))
            decided_cap = 8'd0;
        else if (v > 32'(CAP_SATURATE))
            decided_cap = CAP_SATURATE;
        else
            decided_cap = v[7:0];
        scan_phase = SCAN_DONE;
    endtask

    task automatic predict_cap(input logic [7:0] b, input logic is_last_w);
        csc_result_t res;
        logic [31:0] v;
        logic [1:0]  idx;
        if (scan_phase != SCAN_OVER)
        begin
            if (seen_count >= 32'(cfg_limit))
                scan_phase = SCAN_OVER;
            else
            begin
                seen_count++;
                case (scan_phase)
                    SCAN_HEADER:
                    begin
                        if (hdr_count < 3'd4)
                            tag_acc |= 32'(b) << (8 * hdr_count);
                        else
                            len_acc |= 32'(b) << (8 * (hdr_count - 3'd4));
                        if (hdr_count == 3'd7)
                        begin
                            hdr_count = 3'd0;
                            value_acc = 32'd0;
                            if (tag_acc == cfg_tag && len_acc == SMALL_LEN)
                            begin
                                body_left  = SMALL_LEN;
                                scan_phase = SCAN_VALUE4;
                            end
                            else if (tag_acc == cfg_tag && len_acc == TABLE_LEN)
                            begin
                                body_left  = TABLE_LEN;
                                value_acc  = 32'(NEUTRAL_CODE);
                                scan_phase = SCAN_MAX256;
                            end
                            else
                            begin
                                body_left  = len_acc;
                                scan_phase = (len_acc == 32'd0) ? SCAN_HEADER : SCAN_SKIP;
                            end
                            tag_acc = 32'd0;
                            len_acc = 32'd0;
                        end
                        else
                            hdr_count++;
                    end
                    SCAN_SKIP:
                    begin
                        body_left--;
                        if (body_left == 32'd0)
                            scan_phase = SCAN_HEADER;
                    end
                    SCAN_VALUE4:
                    begin
                        idx = 2'(SMALL_LEN - body_left);
                        value_acc |= 32'(b) << (8 * idx);
                        body_left--;
                        if (body_left == 32'd0)
                            settle_cap(value_acc);
                    end
                    SCAN_MAX256:
                    begin
                        v = (b == 8'd0) ? 32'(NEUTRAL_CODE) : 32'(b);
                        if (v > value_acc)
                            value_acc = v;
                        body_left--;
                        if (body_left == 32'd0)
                            settle_cap(value_acc);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        if (is_last_w)
        begin
            if (scan_phase == SCAN_OVER)
            begin
                res.cap_value   = 8'd0;
                res.scan_status = STATUS_OVER;
            end
            else if (scan_phase == SCAN_DONE)
            begin
                res.cap_value   = decided_cap;
                res.scan_status = STATUS_DECIDED;
            end
            else
            begin
                res.cap_value   = 8'd0;
                res.scan_status = STATUS_NONE;
            end
            queue_expected(res);
            clear_scan();
        end
    endtask

    // byte sender
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            byte_ch.valid     <= 1'b0;
            byte_ch.data_byte <= 8'd0;
            byte_ch.is_last   <= 1'b0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                predict_cap(byte_ch.data_byte, byte_ch.is_last);
                words_sent++;
            end
            if (!byte_ch.valid || byte_ch.ready)
            begin
                if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    byte_word_t w;
                    w = pending_words.pop_front();
                    byte_ch.valid     <= 1'b1;
                    byte_ch.data_byte <= w.data_byte;
                    byte_ch.is_last   <= w.is_last;
                end
                else
                    byte_ch.valid <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (cap_expected.size() == 0)
                    report_mismatch("unexpected result, cap_value", res_ch.cap_value, -1);
                else
                begin
                    csc_result_t e;
                    e = cap_expected.pop_front();
                    if (res_ch.cap_value !== e.cap_value)
                        report_mismatch("cap_value", res_ch.cap_value, e.cap_value);
                    if (res_ch.scan_status !== e.scan_status)
                        report_mismatch("scan_status", res_ch.scan_status, e.scan_status);
                    if (e.scan_status <= STATUS_OVER)
                        status_seen[e.scan_status]++;
                    results_checked++;
                end
            end
            res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic wait_drained();
        while (pending_words.size() != 0 || byte_ch.valid || cap_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_TARGET_TAG)
            cfg_tag = data;
        else
            cfg_limit = data[LIMIT_W-1:0];
    endtask

    task automatic put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            append_file_byte(w[8*i +: 8]);
    endtask

    task automatic put_header(input logic [31:0] tag, input logic [31:0] len);
        put_word(tag);
        put_word(len);
    endtask

    task automatic put_bytes(input int n);
        for (int i = 0; i < n; i++)
            append_file_byte(8'($urandom_range(0, 255)));
    endtask

    // 0 all zero, 1 at most neutral, 2 any, 3 one peak at saturation
    task automatic put_table(input int fill_kind);
        int peak;
        peak = $urandom_range(0, 255);
        put_header(cfg_tag, TABLE_LEN);
        for (int i = 0; i < 256; i++)
        begin
            case (fill_kind)
                0: append_file_byte(8'd0);
                1: append_file_byte(8'($urandom_range(0, 104)));
                2: append_file_byte(8'($urandom_range(0, 255)));
                default: append_file_byte((i == peak) ? 8'd255 : 8'($urandom_range(0, 254)));
            endcase
        end
    endtask

    task automatic send_file();
        byte_word_t w;
        for (int i = 0; i < file_buf.size(); i++)
        begin
            w.data_byte = file_buf[i];
            w.is_last   = (i == file_buf.size() - 1);
            queue_word(w);
        end
        file_buf.delete();
        files_sent++;
    endtask

    function automatic logic [31:0] pick_cap_word();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'(NEUTRAL_CODE);
            2: return 32'hFFFF_FFFF;
            3: return 32'd256;
            4: return 32'(CAP_SATURATE);
            5: return 32'($urandom_range(1, 255));
            6: return 32'($urandom_range(100, 108));
            7: return $urandom;
            8: return 32'($urandom_range(0, 255)) << (8 * $urandom_range(1, 3));
            default: return 32'($urandom_range(1, 300));
        endcase
    endfunction

    function automatic logic [31:0] pick_other_tag();
        logic [31:0] t;
        if ($urandom_range(0, 1) == 0)
            t = $urandom;
        else
            t = cfg_tag ^ (32'd1 << $urandom_range(0, 31));
        if (t == cfg_tag)
            t = t ^ 32'd1;
        return t;
    endfunction

    task automatic build_random_file();
        int c;
        int n_chunks;
        int cut;
        logic [31:0] len;
        if ($urandom_range(0, 99) < 12)
            put_bytes($urandom_range(1, 24));
        else
        begin
            n_chunks = $urandom_range(1, 3);
            for (int k = 0; k < n_chunks; k++)
            begin
                c = $urandom_range(0, 99);
                if (c < 28)
                begin
                    len = $urandom_range(0, 10);
                    put_header(pick_other_tag(), len);
                    put_bytes(len);
                end
                else if (c < 40)
                begin
                    len = $urandom_range(0, 12);
                    if (len == SMALL_LEN)
                        len = 32'd5;
                    put_header(cfg_tag, len);
                    put_bytes(len);
                end
                else if (c < 90)
                begin
                    put_header(cfg_tag, SMALL_LEN);
                    put_word(pick_cap_word());
                end
                else if (c < 95)
                    put_table($urandom_range(0, 3));
                else
                begin
                    // body of random length, usually far longer than the bytes that follow it
                    put_header(pick_other_tag(), $urandom);
                    put_bytes($urandom_range(0, 6));
                    break;
                end
            end
            if ($urandom_range(0, 99) < 20)
                put_bytes($urandom_range(1, 6));
            if ($urandom_range(0, 99) < 15 && file_buf.size() > 1)
            begin
                cut = $urandom_range(1, file_buf.size() - 1);
                repeat (cut) void'(file_buf.pop_back());
            end
        end
        if (file_buf.size() == 0)
            put_bytes(1);
        send_file();
    endtask

    initial
    begin
        int phase_words;
        int phase_files;
        cfg_we            = 1'b0;
        cfg_index         = REG_TARGET_TAG;
        cfg_data          = 32'd0;
        mismatches        = 0;
        files_sent        = 0;
        words_sent        = 0;
        results_checked   = 0;
        status_seen       = '{0, 0, 0};
        send_idle_pct     = 11;
        recv_idle_pct     = 64;
        cfg_tag           = TARGET_TAG_RESET;
        cfg_limit         = FILE_LIMIT_RESET;
        clear_scan();
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed files at the reset settings
        put_bytes(1);
        send_file();
        put_header(cfg_tag, SMALL_LEN);
        put_word(32'd0);
        send_file();
        put_header(cfg_tag, SMALL_LEN);
        put_word(32'(NEUTRAL_CODE));
        send_file();
        put_header(cfg_tag, SMALL_LEN);
        put_word(32'hFFFF_FFFF);
        send_file();
        put_header(cfg_tag, SMALL_LEN);
        put_word(32'd200);
        put_bytes(5);
        send_file();
        put_header(pick_other_tag(), 32'd0);
        put_header(cfg_tag, SMALL_LEN);
        put_word(32'd1);
        send_file();
        put_header(pick_other_tag(), 32'd3);
        put_bytes(3);
        put_header(cfg_tag, 32'd7);
        put_bytes(7);
        put_header(cfg_tag, SMALL_LEN);
        put_word(32'd256);
        send_file();
        put_table(0);
        send_file();
        put_table(3);
        send_file();
        put_header(cfg_tag, SMALL_LEN);
        put_bytes(2);
        send_file();
        put_header(cfg_tag, SMALL_LEN);
        void'(file_buf.pop_back());
        void'(file_buf.pop_back());
        void'(file_buf.pop_back());
        send_file();
        put_header(cfg_tag, SMALL_LEN);
        put_word(32'd7);
        put_header(cfg_tag, SMALL_LEN);
        put_word(32'd9);
        send_file();

        // size limit edges
        wait_drained();
        write_reg(REG_FILE_SIZE_LIMIT, 32'd20);
        put_header(cfg_tag, SMALL_LEN);
        put_word(32'd50);
        put_header(pick_other_tag(), 32'd0);
        send_file();
        put_header(cfg_tag, SMALL_LEN);
        put_word(32'd50);
        put_header(pick_other_tag(), 32'd0);
        put_bytes(1);
        send_file();
        wait_drained();
        write_reg(REG_FILE_SIZE_LIMIT, 32'd1);
        put_bytes(1);
        send_file();
        put_bytes(2);
        send_file();
        wait_drained();
        write_reg(REG_FILE_SIZE_LIMIT, 32'd0);
        put_bytes(1);
        send_file();
        put_bytes(3);
        send_file();

        // tag extremes
        wait_drained();
        write_reg(REG_FILE_SIZE_LIMIT, 32'(FILE_LIMIT_RESET));
        write_reg(REG_TARGET_TAG, 32'd0);
        put_header(cfg_tag, SMALL_LEN);
        put_word(32'd3);
        send_file();
        wait_drained();
        write_reg(REG_TARGET_TAG, 32'hFFFF_FFFF);
        put_header(cfg_tag, SMALL_LEN);
        put_word(32'hFFFF_FFFF);
        send_file();

        // random files under changing settings and idle patterns
        for (int p = 0; p < 6; p++)
        begin
            wait_drained();
            case (p / 2)
                0:
                begin
                    send_idle_pct = 11;
                    recv_idle_pct = 64;
                end
                1:
                begin
                    send_idle_pct = 64;
                    recv_idle_pct = 11;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (p)
                0:
                begin
                    write_reg(REG_TARGET_TAG, $urandom);
                    write_reg(REG_FILE_SIZE_LIMIT, 32'd134217728);
                end
                1:
                begin
                    write_reg(REG_TARGET_TAG, 32'hFFFF_FFFF);
                    write_reg(REG_FILE_SIZE_LIMIT, $urandom_range(16, 60));
                end
                2:
                begin
                    write_reg(REG_TARGET_TAG, TARGET_TAG_RESET);
                    write_reg(REG_FILE_SIZE_LIMIT, 32'(FILE_LIMIT_RESET));
                end
                3:
                begin
                    write_reg(REG_TARGET_TAG, $urandom);
                    write_reg(REG_FILE_SIZE_LIMIT, $urandom_range(1, 40));
                end
                4:
                begin
                    write_reg(REG_TARGET_TAG, 32'd0);
                    write_reg(REG_FILE_SIZE_LIMIT, 32'd134217728);
                end
                default:
                begin
                    write_reg(REG_TARGET_TAG, $urandom);
                    write_reg(REG_FILE_SIZE_LIMIT, $urandom_range(100, 400));
                end
            endcase
            phase_words = 0;
            phase_files = 0;
            while (phase_words < 100 || phase_files < 2)
            begin
                build_random_file();
                phase_words = pending_words.size();
                phase_files++;
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (cap_expected.size() != 0)
            report_mismatch("results never delivered", 0, cap_expected.size());
        $display("covered %0d files in %0d words, %0d results checked", files_sent,
                 words_sent, results_checked);
        $display("status mix: %0d none, %0d decided, %0d too large; %0d mismatches",
                 status_seen[0], status_seen[1], status_seen[2], mismatches);
        if (mismatches == 0)
            $display("chunk_stream_cap_scanner_core_tb passed");
        else
            $display("chunk_stream_cap_scanner_core_tb failed");
        $finish;
    end

endmodule
